// ----- rtl/ocs_pkg.sv -----
// shared types, constants and chip table of the o-qpsk chip spreader
package ocs_pkg;

	// depth of the job queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// most words one request can cause
	localparam int unsigned MAX_WORDS = 4;
	localparam int unsigned CNT_W     = $clog2(MAX_WORDS + 1);
	localparam int unsigned IDX_W     = $clog2(MAX_WORDS);

	localparam int unsigned WORD_W = 32;
	localparam int unsigned SYM_N  = 16;

	// bit positions used when stitching adjacent symbols
	localparam int unsigned I_BIT_POS = WORD_W - 2;
	localparam int unsigned Q_BIT_POS = 1;

	// action codes
	localparam logic ACT_DATA  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// word counts of the three request kinds
	localparam logic [CNT_W-1:0] CNT_FLUSH   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_BYTE    = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_BYTE_PW = CNT_W'(4);

	// two chip words per symbol
	localparam logic [WORD_W-1:0] CHIP_TABLE [SYM_N][2] = '{
		'{32'h6BC3E816, 32'hAA94157C},
		'{32'h7D6BC3E8, 32'h16AA9414},
		'{32'h157D6BC3, 32'hE816AA94},
		'{32'h14157D6B, 32'hC3E816AA},
		'{32'h2A94157D, 32'h6BC3E816},
		'{32'h16AA9415, 32'h7D6BC3E8},
		'{32'h6816AA94, 32'h157D6BC2},
		'{32'h43E816AA, 32'h94157D6A},
		'{32'h416942BC, 32'h003EBFD6},
		'{32'h57C16942, 32'hBC003EBE},
		'{32'h3FD7C169, 32'h42BC003E},
		'{32'h3EBFD7C1, 32'h6942BC00},
		'{32'h003EBFD7, 32'hC16942BC},
		'{32'h3C003EBF, 32'hD7C16942},
		'{32'h42BC003E, 32'hBFD7C168},
		'{32'h6942BC00, 32'h3EBFD7C0}
	};

	// one job: the finished words of one request, first word in slot 0
	typedef struct packed {
		logic [MAX_WORDS-1:0][WORD_W-1:0] words;
		logic [CNT_W-1:0]                 count;
	} job_t;

	// handshake between a job producer and the queue
	typedef struct packed {
		logic push;
		job_t job;
	} job_wr_t;

	// handshake between the queue and the job consumer
	typedef struct packed {
		logic avail;
		job_t job;
	} job_rd_t;

endpackage

// ----- rtl/ocs_in_if.sv -----
// request channel of the chip spreader
interface ocs_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;
	logic       starts_frame;

	modport source(output valid, action, data_byte, starts_frame, input ready);
	modport sink(input valid, action, data_byte, starts_frame, output ready);
endinterface

// ----- rtl/ocs_out_if.sv -----
// chip word channel of the chip spreader
interface ocs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] chip_word;
	logic        last_of_run;

	modport source(output valid, chip_word, last_of_run, input ready);
	modport sink(input valid, chip_word, last_of_run, output ready);
endinterface

// ----- rtl/ocs_front.sv -----
// front end: accepts requests, looks up and stitches chip words, keeps the pending word
module ocs_front (
	input  logic           clk,
	input  logic           arst_n,
	ocs_in_if.sink         in_ch,
	input  logic           q_full,
	output ocs_pkg::job_wr_t q_wr
);
	import ocs_pkg::*;

	logic [WORD_W-1:0] pending_word_q;
	logic              pending_valid_q;

	logic [3:0]        lo_sym, hi_sym;
	logic [WORD_W-1:0] lo_first, lo_second, hi_first, hi_second, held;
	logic              stitch_pend;
	logic              accept;
	job_t              job;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// table lookup and stitching
	always_comb begin
		lo_sym      = in_ch.data_byte[3:0];
		hi_sym      = in_ch.data_byte[7:4];
		stitch_pend = pending_valid_q && !in_ch.starts_frame;
		lo_first    = CHIP_TABLE[lo_sym][0];
		lo_second   = CHIP_TABLE[lo_sym][1];
		hi_first    = CHIP_TABLE[hi_sym][0];
		hi_second   = CHIP_TABLE[hi_sym][1];
		held        = pending_word_q;
		if (stitch_pend) begin
			held[0]            = pending_word_q[0] | lo_first[I_BIT_POS];
			lo_first[WORD_W-1] = lo_first[WORD_W-1] | pending_word_q[Q_BIT_POS];
		end
		hi_first[WORD_W-1] = hi_first[WORD_W-1] | lo_second[Q_BIT_POS];
		lo_second[0]       = lo_second[0] | hi_first[I_BIT_POS];
	end

	// build the job for the queue
	always_comb begin
		job = '0;
		if (in_ch.action == ACT_FLUSH) begin
			job.words[0] = pending_word_q;
			job.count    = pending_valid_q ? CNT_FLUSH : '0;
		end else if (pending_valid_q) begin
			job.words[0] = held;
			job.words[1] = lo_first;
			job.words[2] = lo_second;
			job.words[3] = hi_first;
			job.count    = CNT_BYTE_PW;
		end else begin
			job.words[0] = lo_first;
			job.words[1] = lo_second;
			job.words[2] = hi_first;
			job.count    = CNT_BYTE;
		end
	end

	assign q_wr.push = accept && (job.count != '0);
	assign q_wr.job  = job;

	// pending word state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_valid_q <= 1'b0;
			pending_word_q  <= '0;
		end else if (accept) begin
			if (in_ch.action == ACT_FLUSH) begin
				pending_valid_q <= 1'b0;
			end else begin
				pending_valid_q <= 1'b1;
				pending_word_q  <= hi_second;
			end
		end
	end

	// a data byte always leaves a word pending
	a_byte_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.action == ACT_DATA) |=> pending_valid_q)
		else $error("data byte did not leave a pending word");

	// a flush always clears the pending word
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.action == ACT_FLUSH) |=> !pending_valid_q)
		else $error("flush left a pending word");

	// no job is pushed into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !q_full)
		else $error("job pushed into full queue");

endmodule

// ----- rtl/ocs_queue.sv -----
// short job queue between the front and back ends
module ocs_queue #(
	parameter int unsigned DEPTH = ocs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ocs_pkg::job_wr_t wr,
	output logic             full,
	input  logic             pop,
	output ocs_pkg::job_rd_t rd
);
	import ocs_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned OCC_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0] occ_q;
	logic             do_pop;

	assign full     = (occ_q == FULL_OCC);
	assign rd.avail = (occ_q != '0);
	assign rd.job   = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd.avail;

	// storage
	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.job;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr.push, do_pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	// occupancy stays within the depth
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= FULL_OCC)
		else $error("queue occupancy out of range");

	// a pop with nothing stored leaves the read pointer in place
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !rd.avail) |=> $stable(rd_ptr_q))
		else $error("read pointer moved on empty queue");

	// queued jobs always carry at least one word
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rd.avail |-> (rd.job.count != '0))
		else $error("empty job in queue");

endmodule

// ----- rtl/ocs_back.sv -----
// back end: plays out the words of each job, one per cycle while out_ch.ready is high
module ocs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ocs_pkg::job_rd_t rd,
	output logic             pop,
	ocs_out_if.source        out_ch
);
	import ocs_pkg::*;

	job_t             cur_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             last;
	logic             out_acc;
	logic             done;

	assign last    = ({1'b0, idx_q} + 1'b1) == cur_q.count;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign done    = out_acc && last;
	assign pop     = rd.avail && (!busy_q || done);

	assign out_ch.valid       = busy_q;
	assign out_ch.chip_word   = cur_q.words[idx_q];
	assign out_ch.last_of_run = last;

	// job register and word index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (out_acc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd.job;
		end
	end

	// the index never runs past the job's word count
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, idx_q} < cur_q.count))
		else $error("word index beyond job");

	// a word taken mid-job advances to the next word
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !last && !pop) |=> (busy_q && idx_q == $past(idx_q) + 1'b1))
		else $error("word index did not advance");

	// a stalled word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !out_ch.ready) |=> (busy_q && $stable(idx_q)))
		else $error("stalled word changed");

endmodule

// ----- rtl/oqpsk_chip_spreader.sv -----
// top level of the o-qpsk chip spreader
//
// requests arrive on in_ch: a data byte (action 0) or a flush (action 1).
// each data byte is spread into chip words on out_ch, low nibble first;
// the high symbol's second word is held back so the next symbol can stitch
// it, and comes out with the next byte or with a flush. last_of_run marks
// the final word caused by a request.
// words per request: a flush gives one word (none if nothing is held), a
// byte gives three, or four when a held word goes out ahead of it.
// the front end takes a request in any cycle the job queue has room, so the
// input never waits on a single stalled word; the back end sends one word
// per cycle while out_ch.ready is high, so the output sets the byte rate;
// a job is registered in the queue, then in the back end's job register.
// reset clears the held word, the job queue and the output side.
// when the receiver stalls, the current word holds on out_ch, the queue
// fills, and then in_ch.ready drops until a job is drained.
module oqpsk_chip_spreader #(
	parameter int unsigned QUEUE_DEPTH = ocs_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	ocs_in_if.sink    in_ch,
	ocs_out_if.source out_ch
);
	import ocs_pkg::*;

	job_wr_t q_wr;
	job_rd_t q_rd;
	logic    q_full;
	logic    q_pop;

	// request decode and stitching
	ocs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	// job queue
	ocs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.full   (q_full),
		.pop    (q_pop),
		.rd     (q_rd)
	);

	// word playout
	ocs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (q_rd),
		.pop    (q_pop),
		.out_ch (out_ch)
	);

endmodule

// ----- tb/oqpsk_chip_spreader_test.sv -----
// self-checking testbench of the o-qpsk chip spreader with its chip word scoreboard
`timescale 1ns / 100ps

package ocs_tb_pkg;

	// one expected output word
	typedef struct {
		logic [31:0] word;
		logic        last;
	} chip_exp_t;

	// spreading codes, two words per symbol
	localparam bit [31:0] SPREAD_CODES [16][2] = '{
		'{32'h6BC3E816, 32'hAA94157C},
		'{32'h7D6BC3E8, 32'h16AA9414},
		'{32'h157D6BC3, 32'hE816AA94},
		'{32'h14157D6B, 32'hC3E816AA},
		'{32'h2A94157D, 32'h6BC3E816},
		'{32'h16AA9415, 32'h7D6BC3E8},
		'{32'h6816AA94, 32'h157D6BC2},
		'{32'h43E816AA, 32'h94157D6A},
		'{32'h416942BC, 32'h003EBFD6},
		'{32'h57C16942, 32'hBC003EBE},
		'{32'h3FD7C169, 32'h42BC003E},
		'{32'h3EBFD7C1, 32'h6942BC00},
		'{32'h003EBFD7, 32'hC16942BC},
		'{32'h3C003EBF, 32'hD7C16942},
		'{32'h42BC003E, 32'hBFD7C168},
		'{32'h6942BC00, 32'h3EBFD7C0}
	};

	class chip_scoreboard;
		bit [31:0] held_word;
		bit        held_valid;
		chip_exp_t chip_q[$];
		int        errors;
		int        words_checked;

		function new();
			held_word     = '0;
			held_valid    = 1'b0;
			errors        = 0;
			words_checked = 0;
		endfunction

		// i bit of the next first word into bit 0, q bit of the held word into bit 31
		function void join_symbols(inout bit [31:0] held, inout bit [31:0] next_first);
			bit i_bit;
			bit q_bit;
			i_bit = next_first[30];
			q_bit = held[1];
			held[0]       = held[0] | i_bit;
			next_first[31] = next_first[31] | q_bit;
		endfunction

		function void push_word(bit [31:0] w, bit last);
			chip_exp_t e;
			e.word = w;
			e.last = last;
			chip_q.push_back(e);
		endfunction

		// work out the words one accepted request causes
		function void note_request(bit act, bit [7:0] data_byte, bit starts_frame);
			bit [31:0] lo_first;
			bit [31:0] lo_second;
			bit [31:0] hi_first;
			bit [31:0] hi_second;
			bit [31:0] held;
			if (act == ocs_pkg::ACT_FLUSH) begin
				if (held_valid) begin
					push_word(held_word, 1'b1);
					held_valid = 1'b0;
				end
			end else begin
				lo_first  = SPREAD_CODES[data_byte[3:0]][0];
				lo_second = SPREAD_CODES[data_byte[3:0]][1];
				hi_first  = SPREAD_CODES[data_byte[7:4]][0];
				hi_second = SPREAD_CODES[data_byte[7:4]][1];
				// held word goes out first, patched unless a frame starts
				if (held_valid) begin
					held = held_word;
					if (!starts_frame)
						join_symbols(held, lo_first);
					push_word(held, 1'b0);
				end
				join_symbols(lo_second, hi_first);
				push_word(lo_first, 1'b0);
				push_word(lo_second, 1'b0);
				push_word(hi_first, 1'b1);
				held_word  = hi_second;
				held_valid = 1'b1;
			end
		endfunction

		// compare one accepted word with the oldest expectation
		function void check_word(logic [31:0] chip_word, logic last_of_run);
			chip_exp_t e;
			if (chip_q.size() == 0) begin
				$error("unexpected chip word %h last_of_run %b", chip_word, last_of_run);
				errors++;
				return;
			end
			e = chip_q.pop_front();
			words_checked++;
			if (chip_word !== e.word) begin
				$error("chip_word: expected %h, actual %h", e.word, chip_word);
				errors++;
			end
			if (last_of_run !== e.last) begin
				$error("last_of_run: expected %b, actual %b", e.last, last_of_run);
				errors++;
			end
		endfunction

		function int outstanding();
			return chip_q.size();
		endfunction
	endclass

endpackage

module oqpsk_chip_spreader_test;
	import ocs_tb_pkg::*;

	localparam int IDLE_LIMIT   = 3000;
	localparam int RANDOM_ITEMS = 430;
	localparam int DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;

	ocs_in_if  in_ch();
	ocs_out_if out_ch();

	oqpsk_chip_spreader DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	chip_scoreboard sb = new();

	bit quiet = 1'b0;
	int bytes_sent = 0;
	int flushes_sent = 0;
	int idle_cycles = 0;

	// clock
	always #4 clk = ~clk;

	// sender gap: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// one request, held until accepted; valid stays high for a back-to-back request
	task automatic issue(input bit act, input bit [7:0] data_byte, input bit starts_frame);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.action       <= act;
		in_ch.data_byte    <= data_byte;
		in_ch.starts_frame <= starts_frame;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_request(act, data_byte, starts_frame);
		if (act == ocs_pkg::ACT_FLUSH)
			flushes_sent++;
		else
			bytes_sent++;
	endtask

	task automatic run_directed();
		// flush with nothing held, then a non-start byte with nothing held
		issue(ocs_pkg::ACT_FLUSH, 8'hFF, 1'b1);
		issue(ocs_pkg::ACT_DATA, 8'h00, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'hFF, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'h0F, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'hF0, 1'b0);
		// start of frame with a held word
		issue(ocs_pkg::ACT_DATA, 8'h5A, 1'b1);
		// flush with a held word, then again with nothing held
		issue(ocs_pkg::ACT_FLUSH, 8'h00, 1'b0);
		issue(ocs_pkg::ACT_FLUSH, 8'hA5, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'h12, 1'b1);
		issue(ocs_pkg::ACT_DATA, 8'h34, 1'b0);
		issue(ocs_pkg::ACT_FLUSH, 8'hFF, 1'b1);
		// every nibble value in at least one of the two halves
		issue(ocs_pkg::ACT_DATA, 8'h10, 1'b1);
		issue(ocs_pkg::ACT_DATA, 8'h32, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'h54, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'h76, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'h98, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'hBA, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'hDC, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'hFE, 1'b0);
		issue(ocs_pkg::ACT_DATA, 8'h01, 1'b0);
		issue(ocs_pkg::ACT_FLUSH, 8'h00, 1'b0);
	endtask

	// mostly whole frames with random bytes, some noise requests in between
	task automatic run_random();
		int sent;
		int frame_len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet = (sent >= 200 && sent < 280);
			if ($urandom_range(0, 99) < 75) begin
				issue(ocs_pkg::ACT_DATA, 8'($urandom), 1'b1);
				frame_len = $urandom_range(1, 10);
				repeat (frame_len) issue(ocs_pkg::ACT_DATA, 8'($urandom), 1'b0);
				sent += frame_len + 1;
				if ($urandom_range(0, 4) != 0) begin
					issue(ocs_pkg::ACT_FLUSH, 8'($urandom), 1'($urandom));
					sent++;
				end
			end else begin
				issue(1'($urandom), 8'($urandom), 1'($urandom));
				sent++;
			end
		end
		quiet = 1'b0;
	endtask

	// receiver: runs of ready broken by stalls, always ready in the quiet stretch
	initial begin
		int  hold;
		bit  level;
		out_ch.ready = 1'b0;
		hold  = 0;
		level = 1'b0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				out_ch.ready <= 1'b1;
			end else begin
				if (hold == 0) begin
					level = !level;
					if (level)
						hold = $urandom_range(1, 20);
					else if ($urandom_range(0, 9) == 0)
						hold = $urandom_range(10, 40);
					else
						hold = $urandom_range(1, 3);
				end
				hold--;
				out_ch.ready <= level;
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_word(out_ch.chip_word, out_ch.last_of_run);
	end

	// watchdog on cycles without any accepted request or word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL oqpsk_chip_spreader");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.action       = ocs_pkg::ACT_DATA;
		in_ch.data_byte    = 8'h00;
		in_ch.starts_frame = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random();
		in_ch.valid <= 1'b0;

		// drain, then watch for stray words
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d data bytes and %0d flush requests, %0d chip words checked",
			bytes_sent, flushes_sent, sb.words_checked);
		$display("mismatches found: %0d", sb.errors);
		if (sb.errors == 0)
			$display("PASS oqpsk_chip_spreader");
		else
			$display("FAIL oqpsk_chip_spreader");
		$finish;
	end

endmodule
